FILE: sv/lkvm_pkg.sv
// Package with constants, payload types and control types for the linked key-value map.
package lkvm_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LINK_W   = IDX_W + 1;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int KV_W     = KEY_W + VAL_W;
  localparam int TOTAL_W  = 8;
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(CAPACITY);

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_REMOVE = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_CHK,
    ST_HIT,
    ST_MISS,
    ST_FREE_LD,
    ST_INS1,
    ST_INS2,
    ST_RM1,
    ST_RM2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [VAL_W-1:0]   old_value;
    logic               status;
    logic [TOTAL_W-1:0] entry_total;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic rd_cur;
    logic adv;
    logic hit_ld;
    logic wr_upd;
    logic rd_free;
    logic alloc_free;
    logic alloc_hw;
    logic set_full;
    logic ins1;
    logic ins2;
    logic rm1;
    logic rm2;
    logic done;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  cur_nil;
    logic  match;
    logic  free_nil;
    logic  hw_full;
  } sts_t;

endpackage

FILE: sv/lkvm_ram.sv
// Generic single-port-write, registered-read RAM.
module lkvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/lkvm_ctrl.sv
// Controller state machine sequencing the list walk and the link updates.
module lkvm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lkvm_pkg::sts_t sts,
  output lkvm_pkg::cmd_t cmd
);
  import lkvm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.func == FN_NONE) begin
          state_nxt = ST_DONE;
        end else if (sts.cur_nil) begin
          state_nxt = ST_MISS;
        end else begin
          cmd.rd_cur = 1'b1;
          state_nxt  = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts.match) begin
          cmd.hit_ld = 1'b1;
          state_nxt  = ST_HIT;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_HIT: begin
        priority if (sts.func == FN_INSERT) begin
          cmd.wr_upd = 1'b1;
          state_nxt  = ST_DONE;
        end else if (sts.func == FN_REMOVE) begin
          state_nxt = ST_RM1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MISS: begin
        priority if (sts.func != FN_INSERT) begin
          state_nxt = ST_DONE;
        end else if (!sts.free_nil) begin
          cmd.rd_free = 1'b1;
          state_nxt   = ST_FREE_LD;
        end else if (!sts.hw_full) begin
          cmd.alloc_hw = 1'b1;
          state_nxt    = ST_INS1;
        end else begin
          cmd.set_full = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_FREE_LD: begin
        cmd.alloc_free = 1'b1;
        state_nxt      = ST_INS1;
      end
      ST_INS1: begin
        cmd.ins1  = 1'b1;
        state_nxt = ST_INS2;
      end
      ST_INS2: begin
        cmd.ins2  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_RM1: begin
        cmd.rm1   = 1'b1;
        state_nxt = ST_RM2;
      end
      ST_RM2: begin
        cmd.rm2   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.done  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |=> !cmd.done) else $error("Result strobe lasted more than one cycle.");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> busy) else $error("Block not busy after accepting a transaction.");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |=> !busy) else $error("Block did not return to idle after a result.");

endmodule

FILE: sv/lkvm_dp.sv
// Datapath with the slot memories, list pointers and result registers.
module lkvm_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  lkvm_pkg::req_t in_data,
  input  lkvm_pkg::cmd_t cmd,
  output lkvm_pkg::sts_t sts,
  output lkvm_pkg::rsp_t out_data
);
  import lkvm_pkg::*;

  req_t              req_r;
  logic [LINK_W-1:0] cur_r, head_r, free_r, hw_r, cnt_r, nxt_s_r, prv_s_r;
  logic [IDX_W-1:0]  new_r;
  logic              found_r, status_r;
  logic [VAL_W-1:0]  old_r;

  logic              kv_we, nx_we, pv_we;
  logic [IDX_W-1:0]  kv_wa, nx_wa, pv_wa, nx_ra;
  logic [KV_W-1:0]   kv_wd, kv_rd;
  logic [LINK_W-1:0] nx_wd, pv_wd, nx_rd, pv_rd;

  always_comb begin
    kv_we = 1'b0;
    kv_wa = cur_r[IDX_W-1:0];
    kv_wd = {req_r.key, req_r.value};
    nx_we = 1'b0;
    nx_wa = new_r;
    nx_wd = head_r;
    pv_we = 1'b0;
    pv_wa = new_r;
    pv_wd = NIL_LINK;
    nx_ra = cmd.rd_free ? free_r[IDX_W-1:0] : cur_r[IDX_W-1:0];
    if (cmd.wr_upd) begin
      kv_we = 1'b1;
    end
    if (cmd.ins1) begin
      kv_we = 1'b1;
      kv_wa = new_r;
      nx_we = 1'b1;
      pv_we = 1'b1;
    end
    if (cmd.ins2) begin
      pv_we = (head_r < NIL_LINK);
      pv_wa = head_r[IDX_W-1:0];
      pv_wd = {1'b0, new_r};
    end
    if (cmd.rm1) begin
      nx_we = (prv_s_r < NIL_LINK);
      nx_wa = prv_s_r[IDX_W-1:0];
      nx_wd = nxt_s_r;
      pv_we = (nxt_s_r < NIL_LINK);
      pv_wa = nxt_s_r[IDX_W-1:0];
      pv_wd = prv_s_r;
    end
    if (cmd.rm2) begin
      nx_we = 1'b1;
      nx_wa = cur_r[IDX_W-1:0];
      nx_wd = free_r;
    end
  end

  lkvm_ram #(.WIDTH(KV_W), .DEPTH(CAPACITY)) u_kv (
    .clk(clk), .we(kv_we), .waddr(kv_wa), .wdata(kv_wd),
    .raddr(cur_r[IDX_W-1:0]), .rdata(kv_rd)
  );
  lkvm_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
    .raddr(nx_ra), .rdata(nx_rd)
  );
  lkvm_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
    .raddr(cur_r[IDX_W-1:0]), .rdata(pv_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NIL_LINK;
      free_r <= NIL_LINK;
      hw_r   <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.alloc_hw) begin
        hw_r <= hw_r + LINK_W'(1);
      end
      if (cmd.alloc_free) begin
        free_r <= nx_rd;
      end
      if (cmd.ins2) begin
        head_r <= {1'b0, new_r};
        cnt_r  <= cnt_r + LINK_W'(1);
      end
      if (cmd.rm1 && !(prv_s_r < NIL_LINK)) begin
        head_r <= nxt_s_r;
      end
      if (cmd.rm2) begin
        free_r <= cur_r;
        cnt_r  <= cnt_r - LINK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r    <= in_data;
      cur_r    <= head_r;
      found_r  <= 1'b0;
      old_r    <= '0;
      status_r <= 1'b0;
    end
    if (cmd.adv) begin
      cur_r <= nx_rd;
    end
    if (cmd.hit_ld) begin
      found_r <= 1'b1;
      old_r   <= kv_rd[VAL_W-1:0];
      nxt_s_r <= nx_rd;
      prv_s_r <= pv_rd;
    end
    if (cmd.alloc_hw) begin
      new_r <= hw_r[IDX_W-1:0];
    end
    if (cmd.alloc_free) begin
      new_r <= free_r[IDX_W-1:0];
    end
    if (cmd.set_full) begin
      status_r <= 1'b1;
    end
  end

  assign sts.func     = func_t'(req_r.func);
  assign sts.cur_nil  = !(cur_r < NIL_LINK);
  assign sts.match    = (kv_rd[KV_W-1:VAL_W] == req_r.key);
  assign sts.free_nil = !(free_r < NIL_LINK);
  assign sts.hw_full  = (hw_r == NIL_LINK);

  assign out_data.found       = found_r;
  assign out_data.old_value   = old_r;
  assign out_data.status      = status_r;
  assign out_data.entry_total = TOTAL_W'(cnt_r);

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NIL_LINK) else $error("Entry count exceeds capacity.");
  a_hw_cap: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= NIL_LINK) else $error("Fill mark exceeds capacity.");
  a_cnt_hw: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= hw_r) else $error("More entries than slots ever handed out.");

endmodule

FILE: sv/linked_key_value_map_unit.sv
// Top level of the linked key-value map: controller plus datapath.
// A transaction is taken when start is high and busy is low; its result appears on out_data
// for exactly one cycle with out_valid high and cannot be stalled. The key search visits
// each list entry with one registered memory read and one compare; a remove then unlinks
// the entry and puts its slot on the free list, and an insert of a new key takes a slot
// (reading a free-list slot first to find the next free one) and links it in at the head.
// Slot memories need no clearing pass; untouched slots are handed out from a fill mark.
module linked_key_value_map_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  lkvm_pkg::req_t in_data,
  output logic           out_valid,
  output lkvm_pkg::rsp_t out_data
);
  import lkvm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lkvm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  lkvm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts), .out_data(out_data)
  );

  assign out_valid = cmd.done;

endmodule

FILE: test/linked_key_value_map_unit_test.sv
// Self-checking testbench for the linked key-value map unit, with a predictor and a result queue.
`timescale 1ns / 1ps
module linked_key_value_map_unit_test;
  import lkvm_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_data;
  logic out_valid;
  rsp_t out_data;

  rsp_t expected_rsps[$];
  int error_count = 0;
  int cycle_count = 0;
  int idle_pct;

  logic [KEY_W-1:0] map_keys[$];
  logic [VAL_W-1:0] map_vals[$];

  linked_key_value_map_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // The map keeps newest entries first, so a search from the front sees the same order.
  function automatic rsp_t predict_map(input req_t req);
    rsp_t rsp;
    int idx;
    idx = -1;
    rsp = '0;
    for (int i = 0; i < map_keys.size(); i++) begin
      if (map_keys[i] == req.key && idx < 0) idx = i;
    end
    if (req.func != FN_NONE && idx >= 0) begin
      rsp.found = 1'b1;
      rsp.old_value = map_vals[idx];
    end
    case (func_t'(req.func))
      FN_INSERT: begin
        if (idx >= 0) begin
          map_vals[idx] = req.value;
        end else if (map_keys.size() >= CAPACITY) begin
          rsp.status = 1'b1;
        end else begin
          map_keys.push_front(req.key);
          map_vals.push_front(req.value);
        end
      end
      FN_REMOVE: begin
        if (idx >= 0) begin
          map_keys.delete(idx);
          map_vals.delete(idx);
        end
      end
      default: ;
    endcase
    rsp.entry_total = TOTAL_W'(map_keys.size());
    return rsp;
  endfunction

  task automatic send_request(input func_t func, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    req_t req;
    req.func = func;
    req.key = key;
    req.value = value;
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_rsps.push_back(predict_map(req));
    start <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result: %p", out_data);
        error_count++;
      end else begin
        rsp_t exp_rsp;
        exp_rsp = expected_rsps.pop_front();
        if (out_data.found !== exp_rsp.found) begin
          $error("found: expected %0h, got %0h", exp_rsp.found, out_data.found);
          error_count++;
        end
        if (out_data.old_value !== exp_rsp.old_value) begin
          $error("old_value: expected %0h, got %0h", exp_rsp.old_value, out_data.old_value);
          error_count++;
        end
        if (out_data.status !== exp_rsp.status) begin
          $error("status: expected %0h, got %0h", exp_rsp.status, out_data.status);
          error_count++;
        end
        if (out_data.entry_total !== exp_rsp.entry_total) begin
          $error("entry_total: expected %0d, got %0d", exp_rsp.entry_total,
                 out_data.entry_total);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    if (map_keys.size() > 0 && $urandom_range(99) < 60)
      return map_keys[$urandom_range(map_keys.size() - 1)];
    if ($urandom_range(3) == 0) return $urandom;
    return KEY_W'($urandom_range(200));
  endfunction

  task automatic test_extremes();
    send_request(FN_LOOKUP, '0, '0);
    send_request(FN_REMOVE, '1, '0);
    send_request(FN_INSERT, '0, '1);
    send_request(FN_INSERT, '1, '0);
    send_request(FN_INSERT, 32'h5555_5555, 32'haaaa_aaaa);
    send_request(FN_INSERT, 32'haaaa_aaaa, 32'h5555_5555);
    send_request(FN_INSERT, '0, 32'h1234_5678);
    send_request(FN_LOOKUP, '0, '1);
    send_request(FN_LOOKUP, '1, '1);
    send_request(FN_NONE, '1, '1);
    send_request(FN_REMOVE, 32'h5555_5555, '1);
    send_request(FN_REMOVE, '1, '0);
    send_request(FN_REMOVE, '0, '0);
    send_request(FN_REMOVE, '0, '0);
    send_request(FN_LOOKUP, 32'haaaa_aaaa, '0);
    send_request(FN_REMOVE, 32'haaaa_aaaa, '0);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < CAPACITY; i++) send_request(FN_INSERT, KEY_W'(1000 + i), $urandom);
    send_request(FN_INSERT, '1, '1);
    send_request(FN_INSERT, KEY_W'(1000), '0);
    send_request(FN_REMOVE, KEY_W'(1000 + CAPACITY / 2), '0);
    send_request(FN_INSERT, '1, '1);
    send_request(FN_INSERT, '0, '0);
    for (int i = 0; i < CAPACITY; i++) send_request(FN_REMOVE, KEY_W'(1000 + i), '0);
    send_request(FN_REMOVE, '1, '0);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      int r;
      r = $urandom_range(99);
      if (r < 45) send_request(FN_INSERT, pick_key(), $urandom);
      else if (r < 70) send_request(FN_LOOKUP, pick_key(), $urandom);
      else if (r < 97) send_request(FN_REMOVE, pick_key(), $urandom);
      else send_request(FN_NONE, $urandom, $urandom);
    end
  endtask

  initial begin
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_full_store();
    test_random(105);
    idle_pct = 84;
    test_random(105);
    idle_pct = 19;
    test_random(105);
    idle_pct = 0;
    test_random(105);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (2 * CAPACITY + 20) @(posedge clk);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: files.f
sv/lkvm_pkg.sv
sv/lkvm_ram.sv
sv/lkvm_ctrl.sv
sv/lkvm_dp.sv
sv/linked_key_value_map_unit.sv
test/linked_key_value_map_unit_test.sv
